/* hdl/srtf_pkg.sv */
// shared types and codes of the shortest-remaining-time-first scheduler
package srtf_pkg;

    // fixed widths of the item fields
    localparam int ID_W      = 8;
    localparam int ARRIVAL_W = 32;
    localparam int BURST_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int DONE_W    = 32;
    localparam int STAMP_W   = 32;

    // request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_BURST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE_TICK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RAN        = 3'd4;
    localparam logic [STATUS_W-1:0] ST_COMPLETED  = 3'd5;

    // request item
    typedef struct packed {
        logic                 req_type;
        logic [ID_W-1:0]      proc_id;
        logic [ARRIVAL_W-1:0] arrival_time;
        logic [BURST_W-1:0]   burst_time;
    } req_t;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     run_id;
        logic [DONE_W-1:0]   completion_time;
        logic                all_empty;
    } rsp_t;

    // outcome of the shared compare unit
    typedef struct packed {
        logic lt;    // (a_hi, a_lo) below (b_hi, b_lo)
        logic le_c;  // a_hi at or below c_hi
    } cmp_res_t;

endpackage

/* hdl/srtf_req_if.sv */
// request channel of the scheduler
interface srtf_req_if;
    logic           valid;
    logic           ready;
    srtf_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/srtf_rsp_if.sv */
// result channel of the scheduler
interface srtf_rsp_if;
    logic           valid;
    logic           ready;
    srtf_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/srtf_preemptive_scheduler.sv */
// shortest-remaining-time-first scheduler top level with its sequencer
//
//   channel  dir  handshake      payload
//   req      in   valid / ready  req_type, proc_id, arrival_time, burst_time
//   rsp      out  valid / ready  status, run_id, completion_time, all_empty
//
// an add goes from idle straight to the finish state; a tick sweeps the slot
// table through its one read port in every admission pass and the selection pass
// req is ready only while the sequencer idles; a result waits in the output
// register and only holds the sequencer if a second result is due before it
// is taken; reset clears the slot flags, time and stamp counter at once
module srtf_preemptive_scheduler #(
    parameter int SLOTS      = 16,
    parameter int TIME_BITS  = 32,
    parameter int BURST_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    srtf_req_if.sink req,
    srtf_rsp_if.source rsp
);

    import srtf_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int AW    = (TIME_BITS > ARRIVAL_W) ? TIME_BITS : ARRIVAL_W;
    localparam int BW    = (BURST_BITS > BURST_W) ? BURST_BITS : BURST_W;
    localparam int KEY_W = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADM_SCAN = 3'd1;
    localparam logic [2:0] S_ADM_WR   = 3'd2;
    localparam logic [2:0] S_SEL_SCAN = 3'd3;
    localparam logic [2:0] S_RUN      = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [TIME_BITS-1:0]  arrival;
        logic [BURST_BITS-1:0] remaining;
        logic [STAMP_W-1:0]    stamp;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // control registers
    logic [2:0]           state_reg, state_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [SLOTS-1:0]     adm_reg, adm_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 eval_en_reg, eval_en_next;
    logic                 found_reg, found_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // payload registers
    logic [IDX_W-1:0]    eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    slot_entry_t         best_reg, best_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [DONE_W-1:0]   res_done_reg, res_done_next;
    rsp_t                rsp_data_reg, rsp_data_next;

    // memory and compare unit wiring
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    slot_entry_t         ram_wdata;
    slot_entry_t         ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_raw;
    logic [KEY_W-1:0]    cmp_a_hi, cmp_b_hi, cmp_c_hi;
    logic [STAMP_W-1:0]  cmp_a_lo, cmp_b_lo;
    cmp_res_t            cmp_res;

    // helpers
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic [AW-1:0]         arrival_wide;
    logic [BW-1:0]         burst_wide;
    logic [TIME_BITS-1:0]  arrival_int;
    logic [BURST_BITS-1:0] burst_int;
    logic [TIME_BITS-1:0]  time_inc;
    logic [AW-1:0]         time_inc_wide;
    logic [BURST_BITS-1:0] rem_dec;
    logic                  scan_issue;
    logic                  scan_done;
    logic                  slot_v, slot_a;
    logic                  hit;
    logic                  req_fire;

    // field width conversion
    assign arrival_wide  = AW'(req.data.arrival_time);
    assign burst_wide    = BW'(req.data.burst_time);
    assign arrival_int   = arrival_wide[TIME_BITS-1:0];
    assign burst_int     = burst_wide[BURST_BITS-1:0];
    assign time_inc      = time_reg + TIME_BITS'(1);
    assign time_inc_wide = AW'(time_inc);
    assign rem_dec       = best_reg.remaining - BURST_BITS'(1);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // slot table
    srtf_slot_ram #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = slot_entry_t'(ram_rdata_raw);

    // compare operands: arrival keys while admitting, remaining/stamp while selecting
    always_comb
    begin
        cmp_c_hi = KEY_W'(time_reg);
        if (state_reg == S_ADM_SCAN)
        begin
            cmp_a_hi = KEY_W'(ram_rdata.arrival);
            cmp_a_lo = '0;
            cmp_b_hi = KEY_W'(best_reg.arrival);
            cmp_b_lo = '0;
        end
        else
        begin
            cmp_a_hi = KEY_W'(ram_rdata.remaining);
            cmp_a_lo = ram_rdata.stamp;
            cmp_b_hi = KEY_W'(best_reg.remaining);
            cmp_b_lo = best_reg.stamp;
        end
    end

    srtf_cmp #(
        .HI_W (KEY_W),
        .LO_W (STAMP_W)
    ) u_cmp (
        .a_hi (cmp_a_hi),
        .a_lo (cmp_a_lo),
        .b_hi (cmp_b_hi),
        .b_lo (cmp_b_lo),
        .c_hi (cmp_c_hi),
        .res  (cmp_res)
    );

    // scan bookkeeping and candidate test
    assign scan_issue = (scan_cnt_reg < CNT_W'(SLOTS));
    assign scan_done  = (scan_cnt_reg == CNT_W'(SLOTS)) && !eval_en_reg;
    assign slot_v     = valid_reg[eval_idx_reg];
    assign slot_a     = adm_reg[eval_idx_reg];

    always_comb
    begin
        if (state_reg == S_ADM_SCAN)
        begin
            hit = eval_en_reg && slot_v && !slot_a && cmp_res.le_c &&
                  (!found_reg || cmp_res.lt);
        end
        else
        begin
            hit = eval_en_reg && slot_v && slot_a && (!found_reg || cmp_res.lt);
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        adm_next        = adm_reg;
        time_next       = time_reg;
        stamp_next      = stamp_reg;
        scan_cnt_next   = scan_cnt_reg;
        eval_en_next    = 1'b0;
        eval_idx_next   = scan_cnt_reg[IDX_W-1:0];
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_done_next   = res_done_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = best_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_id_next   = '0;
                    res_done_next = '0;
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    if (req.data.req_type == REQ_TICK)
                    begin
                        state_next = S_ADM_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                        if (burst_int == '0)
                        begin
                            res_status_next = ST_ZERO_BURST;
                        end
                        else if (!free_found)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            res_status_next      = ST_ADDED;
                            valid_next[free_idx] = 1'b1;
                            adm_next[free_idx]   = 1'b0;
                            ram_we               = 1'b1;
                            ram_waddr            = free_idx;
                            ram_wdata.id         = req.data.proc_id;
                            ram_wdata.arrival    = arrival_int;
                            ram_wdata.remaining  = burst_int;
                            ram_wdata.stamp      = '0;
                        end
                    end
                end
            end

            S_ADM_SCAN, S_SEL_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    eval_en_next  = 1'b1;
                end
                if (hit)
                begin
                    found_next    = 1'b1;
                    best_idx_next = eval_idx_reg;
                    best_next     = ram_rdata;
                end
                if (scan_done)
                begin
                    scan_cnt_next = '0;
                    found_next    = 1'b0;
                    if (state_reg == S_ADM_SCAN)
                    begin
                        state_next = found_reg ? S_ADM_WR : S_SEL_SCAN;
                    end
                    else if (found_reg)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        res_status_next = ST_IDLE_TICK;
                        time_next       = time_inc;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_ADM_WR:
            begin
                // admit the earliest arrival found in this pass
                ram_we                 = 1'b1;
                ram_wdata.stamp        = stamp_reg;
                adm_next[best_idx_reg] = 1'b1;
                stamp_next             = stamp_reg + STAMP_W'(1);
                state_next             = S_ADM_SCAN;
            end

            S_RUN:
            begin
                res_id_next = best_reg.id;
                time_next   = time_inc;
                state_next  = S_FINISH;
                if (rem_dec == '0)
                begin
                    res_status_next          = ST_COMPLETED;
                    res_done_next            = time_inc_wide[DONE_W-1:0];
                    valid_next[best_idx_reg] = 1'b0;
                    adm_next[best_idx_reg]   = 1'b0;
                end
                else
                begin
                    res_status_next     = ST_RAN;
                    ram_we              = 1'b1;
                    ram_wdata.remaining = rem_dec;
                    ram_wdata.stamp     = stamp_reg;
                    stamp_next          = stamp_reg + STAMP_W'(1);
                end
            end

            S_FINISH:
            begin
                // hand over once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_data_next.status          = res_status_reg;
                    rsp_data_next.run_id          = res_id_reg;
                    rsp_data_next.completion_time = res_done_reg;
                    rsp_data_next.all_empty       = ~|valid_reg;
                    rsp_valid_next                = 1'b1;
                    state_next                    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            adm_reg       <= '0;
            time_reg      <= '0;
            stamp_reg     <= '0;
            scan_cnt_reg  <= '0;
            eval_en_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            adm_reg       <= adm_next;
            time_reg      <= time_next;
            stamp_reg     <= stamp_next;
            scan_cnt_reg  <= scan_cnt_next;
            eval_en_reg   <= eval_en_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_done_reg   <= res_done_next;
        rsp_data_reg   <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

/* hdl/srtf_slot_ram.sv */
// slot table memory: one write port, one registered read port
module srtf_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 88
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/srtf_cmp.sv */
// shared compare unit: lexicographic less-than and an upper-bound check
module srtf_cmp #(
    parameter int HI_W = 32,
    parameter int LO_W = 32
) (
    input  logic [HI_W-1:0]  a_hi,
    input  logic [LO_W-1:0]  a_lo,
    input  logic [HI_W-1:0]  b_hi,
    input  logic [LO_W-1:0]  b_lo,
    input  logic [HI_W-1:0]  c_hi,
    output srtf_pkg::cmp_res_t res
);

    // primary key first, secondary key breaks ties
    always_comb
    begin
        res.lt   = (a_hi < b_hi) || ((a_hi == b_hi) && (a_lo < b_lo));
        res.le_c = (a_hi <= c_hi);
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench of the shortest-remaining-time-first scheduler: directed and random items
module testbench;
    import srtf_pkg::*;

    localparam int SLOTS        = 16;
    localparam int TIME_BITS    = 32;
    localparam int BURST_BITS   = 16;
    localparam int IDLE_PCT     = 21;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 400;
    localparam int RANDOM_ITEMS = 1650;

    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    srtf_req_if req_ch ();
    srtf_rsp_if rsp_ch ();

    srtf_preemptive_scheduler #(
        .SLOTS      (SLOTS),
        .TIME_BITS  (TIME_BITS),
        .BURST_BITS (BURST_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted scheduler state
    bit                   slot_busy     [SLOTS];
    bit                   slot_ready    [SLOTS];
    bit [ID_W-1:0]        slot_pid      [SLOTS];
    bit [TIME_BITS-1:0]   slot_arrive   [SLOTS];
    bit [BURST_BITS-1:0]  slot_left     [SLOTS];
    bit [STAMP_W-1:0]     slot_age      [SLOTS];
    bit [TIME_BITS-1:0]   now_tick;
    bit [STAMP_W-1:0]     age_counter;

    // outcomes still to come out of the block, oldest first
    rsp_t sched_outcomes[$];
    int   errors = 0;
    int   quiet_cycles = 0;
    bit   no_idle = 1'b0;
    int   holds_asked = 0;

    // advance the predicted scheduler by one item and return its outcome
    function automatic rsp_t schedule_step(input req_t item);
        rsp_t res;
        int   free_slot;
        int   pick;
        res = '0;
        if (item.req_type == REQ_ADD) begin
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (!slot_busy[i] && free_slot < 0)
                    free_slot = i;
            if (item.burst_time[BURST_BITS-1:0] == '0)
                res.status = ST_ZERO_BURST;
            else if (free_slot < 0)
                res.status = ST_FULL;
            else
            begin
                slot_busy[free_slot]   = 1'b1;
                slot_ready[free_slot]  = 1'b0;
                slot_pid[free_slot]    = item.proc_id;
                slot_arrive[free_slot] = item.arrival_time[TIME_BITS-1:0];
                slot_left[free_slot]   = item.burst_time[BURST_BITS-1:0];
                slot_age[free_slot]    = '0;
                res.status = ST_ADDED;
            end
        end
        else
        begin
            // admit arrived processes by arrival, then by lower slot
            do
            begin
                pick = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_busy[i] && !slot_ready[i] && slot_arrive[i] <= now_tick &&
                        (pick < 0 || slot_arrive[i] < slot_arrive[pick]))
                        pick = i;
                if (pick >= 0)
                begin
                    slot_ready[pick] = 1'b1;
                    slot_age[pick]   = age_counter;
                    age_counter      = age_counter + 1'b1;
                end
            end while (pick >= 0);
            // least remaining time, ties to the oldest stamp
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy[i] && slot_ready[i] &&
                    (pick < 0 || slot_left[i] < slot_left[pick] ||
                     (slot_left[i] == slot_left[pick] && slot_age[i] < slot_age[pick])))
                    pick = i;
            if (pick < 0)
                res.status = ST_IDLE_TICK;
            else
            begin
                res.run_id = slot_pid[pick];
                slot_left[pick] = slot_left[pick] - 1'b1;
                if (slot_left[pick] == '0)
                begin
                    res.status          = ST_COMPLETED;
                    res.completion_time = now_tick + 1'b1;
                    slot_busy[pick]     = 1'b0;
                    slot_ready[pick]    = 1'b0;
                end
                else
                begin
                    res.status     = ST_RAN;
                    slot_age[pick] = age_counter;
                    age_counter    = age_counter + 1'b1;
                end
            end
            now_tick = now_tick + 1'b1;
        end
        res.all_empty = 1'b1;
        for (int i = 0; i < SLOTS; i++)
            if (slot_busy[i])
                res.all_empty = 1'b0;
        return res;
    endfunction

    function automatic int busy_slots();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            n += slot_busy[i];
        return n;
    endfunction

    // offer one item, wait for it to be taken, record its outcome
    task automatic send_req(input req_t item);
        rsp_t outcome;
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        outcome = schedule_step(item);
        sched_outcomes.insert(sched_outcomes.size(), outcome);
    endtask

    task automatic send_add(input logic [ID_W-1:0] pid, input logic [ARRIVAL_W-1:0] arrive,
                            input logic [BURST_W-1:0] burst);
        req_t item;
        item              = '0;
        item.req_type     = REQ_ADD;
        item.proc_id      = pid;
        item.arrival_time = arrive;
        item.burst_time   = burst;
        send_req(item);
    endtask

    task automatic send_tick();
        req_t item;
        item          = '0;
        item.req_type = REQ_TICK;
        item.proc_id  = 8'($urandom_range(255));
        send_req(item);
    endtask

    // tick with nothing in the table
    task automatic test_idle_tick();
        send_tick();
    endtask

    // zero burst is refused
    task automatic test_zero_burst();
        send_add(8'h5A, '0, '0);
    endtask

    // one process of one tick finishes at once
    task automatic test_single_completion();
        send_add(8'hFF, '0, 16'd1);
        send_tick();
    endtask

    // same-arrival ties, restamping and a shorter process arriving later
    task automatic test_ties_and_preemption();
        logic [TIME_BITS-1:0] t0;
        t0 = now_tick;
        send_add(8'd1, t0, 16'd3);
        send_add(8'd2, t0, 16'd3);
        send_add(8'd3, t0 + 2, 16'd1);
        repeat (4) send_tick();
    endtask

    // fill every slot, then one more add and a zero-burst add while full
    task automatic test_table_full();
        while (busy_slots() < SLOTS)
            send_add(8'($urandom_range(255)), now_tick + $urandom_range(3),
                     16'($urandom_range(1, 4)));
        send_add(8'h77, now_tick, 16'd7);
        send_add(8'h78, now_tick, 16'd0);
    endtask

    // random adds and ticks, table kept moving between empty and full
    task automatic test_random_mix();
        int busy;
        int add_pct;
        int sel;
        logic [ARRIVAL_W-1:0] arrive;
        logic [BURST_W-1:0]   burst;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= 500 && n < 800);
            if (n == 1000)
                holds_asked++;
            busy    = busy_slots();
            add_pct = (busy < 4) ? 60 : ((busy < 12) ? 45 : 30);
            if ($urandom_range(99) < add_pct)
            begin
                sel = $urandom_range(99);
                if (sel < 65)
                    arrive = now_tick + $urandom_range(15);
                else if (sel < 85)
                    arrive = $urandom_range(now_tick, 0);
                else
                    arrive = now_tick;
                sel = $urandom_range(99);
                if (sel < 3)
                    burst = '0;
                else if (sel < 70)
                    burst = 16'($urandom_range(1, 6));
                else if (sel < 95)
                    burst = 16'($urandom_range(7, 40));
                else
                    burst = 16'($urandom_range(41, 120));
                send_add(8'($urandom_range(255)), arrive, burst);
            end
            else
                send_tick();
        end
        no_idle = 1'b0;
    endtask

    // widest fields: far arrivals and longest bursts stay in the table
    task automatic test_extreme_fields();
        // make room for the three adds
        while (busy_slots() > SLOTS - 3)
            send_tick();
        send_add(8'h00, 32'hFFFF_FFFF, 16'hFFFF);
        send_add(8'hA5, now_tick, 16'hFFFF);
        send_add(8'h3C, 32'h8000_0000, 16'h8000);
        repeat (3) send_tick();
    endtask

    // result side: random stalls plus one long hold on request
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (holds_served < holds_asked)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // compare each result with the oldest outcome
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (sched_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, status %0d run_id %0h",
                         $time, rsp_ch.data.status, rsp_ch.data.run_id);
            end
            else
            begin
                want = sched_outcomes.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_ch.data.status));
                check_field("run_id", 32'(want.run_id), 32'(rsp_ch.data.run_id));
                check_field("completion_time", want.completion_time,
                            rsp_ch.data.completion_time);
                check_field("all_empty", 32'(want.all_empty), 32'(rsp_ch.data.all_empty));
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // test sequence
    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_tick();
        test_zero_burst();
        test_single_completion();
        test_ties_and_preemption();
        test_table_full();
        test_random_mix();
        test_extreme_fields();
        req_ch.valid <= 1'b0;
        wait (sched_outcomes.size() == 0);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
